>>> hdl/assert_macros.svh
// Assertion macros for the RTL files (sampled on clk, disabled in reset)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define EDM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define EDM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/edm_pkg.sv
// Shared types and constants of the pairwise distance engine
`default_nettype none

package edm_pkg;

	localparam int MAX_REFS_DEF   = 64;
	localparam int COORD_BITS_DEF = 24;

	// Width and reset value of the num_refs register
	localparam int              CFG_W        = 7;
	localparam logic [CFG_W-1:0] NUM_REFS_RST = 7'd64;

	typedef enum logic {
		FUNC_LOAD  = 1'b0,
		FUNC_QUERY = 1'b1
	} func_t;

	// Control that travels with each distance through the pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage

`default_nettype wire

>>> hdl/edm_ref_mem.sv
// Reference point table: one write port, one registered read port
`default_nettype none

module edm_ref_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] ram [0:DEPTH-1];
	logic [DW-1:0] rdata_q;

	// Write on load, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			ram[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= ram[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/edm_sqrt.sv
// Pipelined floor square root, one result bit per stage
`default_nettype none

module edm_sqrt #(
	parameter int RW = 25,
	parameter int TW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  edm_pkg::ctl_t   ctl_in,
	input  logic [TW-1:0]   tag_in,
	input  logic [2*RW-1:0] radicand,
	output edm_pkg::ctl_t   ctl_out,
	output logic [TW-1:0]   tag_out,
	output logic [RW-1:0]   root
);

	import edm_pkg::*;

	ctl_t            ctl_s  [0:RW-1];
	logic [TW-1:0]   tag_s  [0:RW-1];
	logic [RW:0]     rem_s  [0:RW-1];
	logic [RW-1:0]   root_s [0:RW-1];
	logic [2*RW-1:0] val_s  [0:RW-1];

	for (genvar i = 0; i < RW; i++) begin : g_stage
		ctl_t            ctl_i;
		logic [TW-1:0]   tag_i;
		logic [RW:0]     rem_in;
		logic [RW-1:0]   root_in;
		logic [2*RW-1:0] val_in;
		logic [RW+2:0]   rem_sh;
		logic [RW+2:0]   trial;
		logic [RW+2:0]   diff;
		logic            take;

		// Select stage input: pipeline entry or previous stage
		if (i == 0) begin : g_first
			assign ctl_i   = ctl_in;
			assign tag_i   = tag_in;
			assign rem_in  = '0;
			assign root_in = '0;
			assign val_in  = radicand;
		end else begin : g_next
			assign ctl_i   = ctl_s[i-1];
			assign tag_i   = tag_s[i-1];
			assign rem_in  = rem_s[i-1];
			assign root_in = root_s[i-1];
			assign val_in  = val_s[i-1];
		end

		// Bring down two radicand bits and try the next root bit
		assign rem_sh = {rem_in, val_in[2*RW-1 -: 2]};
		assign trial  = {1'b0, root_in, 2'b01};
		assign take   = (rem_sh >= trial);
		assign diff   = rem_sh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i] <= '0;
			end else if (en) begin
				ctl_s[i] <= ctl_i;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[i]  <= tag_i;
				val_s[i]  <= val_in << 2;
				rem_s[i]  <= take ? diff[RW:0] : rem_sh[RW:0];
				root_s[i] <= {root_in[RW-2:0], take};
			end
		end
	end

	assign ctl_out = ctl_s[RW-1];
	assign tag_out = tag_s[RW-1];
	assign root    = root_s[RW-1];

endmodule

`default_nettype wire

>>> hdl/euclidean_distance_matrix.sv
// Top level of the pairwise Euclidean distance engine
`default_nettype none

// A load transaction (func 0) writes one reference point into the table and produces no
// result. A query transaction (func 1) streams one distance per reference entry 0 ..
// num_refs-1 (num_refs saturated to MAX_REFS, zero gives no result), one per cycle while the
// output is not stalled, in index order, with last set on the final one. The table has a
// single read port, so a query occupies the input until its last table read; the next
// transaction is taken right after that read, while earlier distances still drain. A distance
// passes through read, difference, square, sum, one square root stage per result bit and the
// output register. Any stall on the output freezes the whole pipeline. Table entries hold
// garbage until loaded; num_refs is written on the cfg channel and resets to 64.
module euclidean_distance_matrix #(
	parameter int MAX_REFS   = edm_pkg::MAX_REFS_DEF,
	parameter int COORD_BITS = edm_pkg::COORD_BITS_DEF,
	localparam int IDX_W     = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [edm_pkg::CFG_W-1:0]     cfg_data,
	// Input items
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [IDX_W-1:0]              ref_slot,
	input  logic signed [COORD_BITS-1:0]  coord_x,
	input  logic signed [COORD_BITS-1:0]  coord_y,
	// Results
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [IDX_W-1:0]              ref_index,
	output logic [COORD_BITS:0]           distance,
	output logic                          last
);

	import edm_pkg::*;

	`include "assert_macros.svh"

	localparam int DW  = COORD_BITS + 1;
	localparam int RW  = DW;
	localparam int CBW = $clog2(MAX_REFS + 1);
	localparam int NW  = (CBW > CFG_W) ? CBW : CFG_W;

	logic [CFG_W-1:0]      num_refs_q;
	logic [NW-1:0]         n_sat;
	logic [NW-1:0]         num_ext;
	logic                  adv;
	logic                  in_acc;
	logic                  is_query;
	logic                  mem_we;
	logic                  issue;
	logic                  issue_last;
	logic                  active_q;
	logic [IDX_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      last_idx_q;
	logic [COORD_BITS-1:0] qx_q;
	logic [COORD_BITS-1:0] qy_q;
	logic [2*COORD_BITS-1:0] rd_data;

	ctl_t                  ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_sq;
	logic [IDX_W-1:0]      idx_s1, idx_s2, idx_s3, idx_s4, idx_sq;
	logic [COORD_BITS-1:0] qx_s1, qy_s1;
	logic signed [DW-1:0]  dx_s2, dy_s2;
	logic signed [2*DW-1:0] px, py;
	logic [2*DW-1:0]       sqx_s3, sqy_s3;
	logic [2*DW-1:0]       sum_s4;
	logic [RW-1:0]         root_sq;

	logic                  out_valid_q;
	logic [IDX_W-1:0]      out_idx_q;
	logic [RW-1:0]         out_dist_q;
	logic                  out_last_q;

	// Configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_refs_q <= NUM_REFS_RST;
		end else if (cfg_valid && cfg_ready) begin
			num_refs_q <= cfg_data;
		end
	end

	// Clamp the run length to the table depth
	assign num_ext = NW'(num_refs_q);
	assign n_sat   = (num_ext > NW'(MAX_REFS)) ? NW'(MAX_REFS) : num_ext;

	// Pipeline moves whenever the output register can take a new value
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = !active_q;
	assign in_acc   = in_valid && in_ready;
	assign is_query = (func == FUNC_QUERY);
	assign mem_we   = in_acc && (func == FUNC_LOAD)
		&& ({1'b0, ref_slot} < (IDX_W+1)'(MAX_REFS));

	assign issue      = active_q && adv;
	assign issue_last = (cnt_q == last_idx_q);

	// Query sequencer: one table read per advancing cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			cnt_q      <= '0;
			last_idx_q <= '0;
		end else if (in_acc && is_query && (n_sat != '0)) begin
			active_q   <= 1'b1;
			cnt_q      <= '0;
			last_idx_q <= IDX_W'(n_sat - NW'(1));
		end else if (issue) begin
			cnt_q <= cnt_q + IDX_W'(1);
			if (issue_last) begin
				active_q <= 1'b0;
			end
		end
	end

	// Hold the query point for the run
	always_ff @(posedge clk) begin
		if (in_acc && is_query) begin
			qx_q <= coord_x;
			qy_q <= coord_y;
		end
	end

	edm_ref_mem #(
		.DEPTH (MAX_REFS),
		.AW    (IDX_W),
		.DW    (2*COORD_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ref_slot),
		.wdata ({coord_x, coord_y}),
		.re    (issue),
		.raddr (cnt_q),
		.rdata (rd_data)
	);

	// Stage control: valid and last through the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s1 <= '{valid: active_q, last: issue_last};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Products of the coordinate differences
	assign px = dx_s2 * dx_s2;
	assign py = dy_s2 * dy_s2;

	// Front datapath: difference, square, sum
	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s1 <= cnt_q;
			qx_s1  <= qx_q;
			qy_s1  <= qy_q;

			idx_s2 <= idx_s1;
			dx_s2  <= $signed({qx_s1[COORD_BITS-1], qx_s1})
				- $signed({rd_data[2*COORD_BITS-1], rd_data[2*COORD_BITS-1 -: COORD_BITS]});
			dy_s2  <= $signed({qy_s1[COORD_BITS-1], qy_s1})
				- $signed({rd_data[COORD_BITS-1], rd_data[COORD_BITS-1:0]});

			idx_s3 <= idx_s2;
			sqx_s3 <= unsigned'(px);
			sqy_s3 <= unsigned'(py);

			idx_s4 <= idx_s3;
			sum_s4 <= sqx_s3 + sqy_s3;
		end
	end

	edm_sqrt #(
		.RW (RW),
		.TW (IDX_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ctl_in   (ctl_s4),
		.tag_in   (idx_s4),
		.radicand (sum_s4),
		.ctl_out  (ctl_sq),
		.tag_out  (idx_sq),
		.root     (root_sq)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_sq.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_idx_q  <= idx_sq;
			out_dist_q <= root_sq;
			out_last_q <= ctl_sq.last;
		end
	end

	assign out_valid = out_valid_q;
	assign ref_index = out_idx_q;
	assign distance  = out_dist_q;
	assign last      = out_last_q;

	// Checks
	`EDM_ASSERT_NEXT(a_run_ends, issue && issue_last, !active_q,
		"sequencer still active after last table read")
	`EDM_ASSERT_NEXT(a_idx_step, out_valid && out_ready && !last,
		out_valid && (ref_index == $past(ref_index) + IDX_W'(1)),
		"results of a run are not contiguous in index order")
	`EDM_ASSERT_NEXT(a_run_start, in_acc && is_query && (n_sat != '0),
		active_q && (cnt_q == '0),
		"query did not start its run at entry zero")

endmodule

`default_nettype wire

>>> bench/euclidean_distance_matrix_chk.sv
`timescale 1ns / 100ps
// Distance predictor and result checker for the pairwise Euclidean distance engine
module euclidean_distance_matrix_chk #(
	parameter int REFS  = 64,
	parameter int CBITS = 24
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [edm_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  logic                      func,
	input  logic [5:0]                ref_slot,
	input  logic signed [CBITS-1:0]   coord_x,
	input  logic signed [CBITS-1:0]   coord_y,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  logic [5:0]                ref_index,
	input  logic [CBITS:0]            distance,
	input  logic                      last,
	output int                        err_count,
	output int                        pending
);

	import edm_pkg::*;

	typedef struct {
		logic [5:0]     idx;
		logic [CBITS:0] dval;
		logic           last;
	} dist_rec_t;

	dist_rec_t              dist_queue[$];
	logic signed [CBITS-1:0] pt_x [REFS];
	logic signed [CBITS-1:0] pt_y [REFS];
	logic [CFG_W-1:0]       ref_count;

	// Floor square root, one result bit at a time from the top
	function automatic logic [CBITS:0] floor_root(longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = CBITS; b >= 0; b--) begin
			trial = root | (longint'(1) << b);
			if (trial * trial <= v)
				root = trial;
		end
		return root[CBITS:0];
	endfunction

	// Distance from a query point to one stored reference point
	function automatic logic [CBITS:0] point_dist(logic signed [CBITS-1:0] qx,
			logic signed [CBITS-1:0] qy, int k);
		longint dx;
		longint dy;
		dx = longint'(qx) - longint'(pt_x[k]);
		dy = longint'(qy) - longint'(pt_y[k]);
		return floor_root(longint'(dx * dx + dy * dy));
	endfunction

	function automatic void report(string what, longint exp_v, longint act_v);
		$display("%0t: %s expected %0d actual %0d", $time, what, exp_v, act_v);
		err_count++;
	endfunction

	always @(posedge clk) begin
		dist_rec_t rec;
		dist_rec_t want;
		int        n;
		if (!arst_n) begin
			dist_queue.delete();
			for (int k = 0; k < REFS; k++) begin
				pt_x[k] = '0;
				pt_y[k] = '0;
			end
			ref_count = NUM_REFS_RST;
			err_count = 0;
			pending   = 0;
		end else begin
			// Apply a register write
			if (cfg_valid && cfg_ready)
				ref_count = cfg_data;

			// Store a reference point or queue up a run of distances
			if (in_valid && in_ready) begin
				if (func_t'(func) == FUNC_LOAD) begin
					pt_x[ref_slot] = coord_x;
					pt_y[ref_slot] = coord_y;
				end else begin
					n = (ref_count > REFS) ? REFS : int'(ref_count);
					for (int k = 0; k < n; k++) begin
						rec.idx  = k[5:0];
						rec.dval = point_dist(coord_x, coord_y, k);
						rec.last = (k == n - 1);
						dist_queue.push_back(rec);
					end
				end
			end

			// Compare a result transaction with the oldest expected distance
			if (out_valid && out_ready) begin
				if (dist_queue.size() == 0) begin
					report("unexpected distance, none pending; ref_index", -1, ref_index);
				end else begin
					want = dist_queue.pop_front();
					if (ref_index !== want.idx)
						report("ref_index", want.idx, ref_index);
					if (distance !== want.dval)
						report("distance", want.dval, distance);
					if (last !== want.last)
						report("last", want.last, last);
				end
			end

			pending = dist_queue.size();
		end
	end

endmodule

>>> bench/euclidean_distance_matrix_tb.sv
`timescale 1ns / 100ps
// Stimulus, clocking and verdict for the pairwise Euclidean distance engine
module euclidean_distance_matrix_tb;
	import edm_pkg::*;

	localparam int REFS       = 64;
	localparam int CBITS      = 24;
	localparam int SETTLE     = CBITS + 16;
	localparam int LIMIT      = 400000;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 38;
	localparam int IDLE_PCT   = 27;
	localparam int CALM_PHASE = 4;

	localparam logic [CBITS-1:0] C_MAX  = 24'h7FFFFF;
	localparam logic [CBITS-1:0] C_MIN  = 24'h800000;
	localparam logic [CBITS-1:0] C_ZERO = 24'h000000;
	localparam logic [CBITS-1:0] C_NEG1 = 24'hFFFFFF;
	localparam logic [CBITS-1:0] C_ONE  = 24'h000001;

	logic                    clk        = 1'b0;
	logic                    arst_n     = 1'b0;
	logic                    cfg_valid  = 1'b0;
	logic                    cfg_ready;
	logic [CFG_W-1:0]        cfg_data   = '0;
	logic                    in_valid   = 1'b0;
	logic                    in_ready;
	logic                    func       = FUNC_LOAD;
	logic [5:0]              ref_slot   = '0;
	logic signed [CBITS-1:0] coord_x    = '0;
	logic signed [CBITS-1:0] coord_y    = '0;
	logic                    out_valid;
	logic                    out_ready  = 1'b0;
	logic [5:0]              ref_index;
	logic [CBITS:0]          distance;
	logic                    last;

	int          fail_count;
	int          dist_pending;
	int          cycle_count = 0;
	bit          no_gaps     = 1'b0;
	logic [REFS-1:0] loaded  = '0;
	int          cur_count   = NUM_REFS_RST;
	int          phase_counts[PHASES] = '{64, 5, 127, 1, 64, 17, 0, 33};

	euclidean_distance_matrix #(
		.MAX_REFS   (REFS),
		.COORD_BITS (CBITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.ref_slot  (ref_slot),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ref_index (ref_index),
		.distance  (distance),
		.last      (last)
	);

	euclidean_distance_matrix_chk #(
		.REFS  (REFS),
		.CBITS (CBITS)
	) chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.ref_slot  (ref_slot),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ref_index (ref_index),
		.distance  (distance),
		.last      (last),
		.err_count (fail_count),
		.pending   (dist_pending)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Stall the result side at random, except in the calm stretch
	initial begin
		forever begin
			@(negedge clk);
			out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Present one transaction and hold it until accepted
	task automatic send(func_t f, logic [5:0] slot, logic [CBITS-1:0] x, logic [CBITS-1:0] y);
		@(negedge clk);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func     <= f;
		ref_slot <= slot;
		coord_x  <= x;
		coord_y  <= y;
		do @(posedge clk); while (!in_ready);
		if (f == FUNC_LOAD)
			loaded[slot] = 1'b1;
	endtask

	// Hold off input until every pending distance is out and the pipeline is empty
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (dist_pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_count(int v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v[CFG_W-1:0];
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_count = v;
	endtask

	function automatic int refs_used();
		return (cur_count > REFS) ? REFS : cur_count;
	endfunction

	function automatic logic [CBITS-1:0] rand_coord();
		logic [CBITS-1:0] v;
		case ($urandom_range(3))
			0, 1: v = CBITS'($urandom);
			2: begin
				case ($urandom_range(4))
					0: v = C_MAX;
					1: v = C_MIN;
					2: v = C_ZERO;
					3: v = C_NEG1;
					default: v = C_ONE;
				endcase
			end
			default: v = CBITS'($urandom_range(4095) - 2048);
		endcase
		return v;
	endfunction

	// Fill the table up to the active count first, then mix loads and queries
	task automatic random_item();
		int gap;
		gap = -1;
		for (int k = refs_used() - 1; k >= 0; k--)
			if (!loaded[k])
				gap = k;
		if (gap >= 0)
			send(FUNC_LOAD, gap[5:0], rand_coord(), rand_coord());
		else if ($urandom_range(99) < 35)
			send(FUNC_LOAD, 6'($urandom_range(REFS - 1)), rand_coord(), rand_coord());
		else
			send(FUNC_QUERY, 6'($urandom), rand_coord(), rand_coord());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: extreme coordinates, both operations, zero count
		set_count(1);
		send(FUNC_LOAD, 6'd0, C_MAX, C_MAX);
		send(FUNC_QUERY, 6'd0, C_MIN, C_MIN);
		send(FUNC_QUERY, 6'd63, C_MAX, C_MAX);
		send(FUNC_LOAD, 6'd63, C_MIN, C_MAX);
		send(FUNC_LOAD, 6'd1, C_MIN, C_MIN);
		set_count(2);
		send(FUNC_QUERY, 6'd0, C_MAX, C_MIN);
		send(FUNC_QUERY, 6'd0, C_ZERO, C_ZERO);
		send(FUNC_LOAD, 6'd0, C_ZERO, C_ZERO);
		send(FUNC_QUERY, 6'd0, C_NEG1, C_ONE);
		send(FUNC_QUERY, 6'd21, 24'h000100, 24'hFFFF00);
		set_count(0);
		send(FUNC_QUERY, 6'd0, C_MAX, C_MAX);
		send(FUNC_LOAD, 6'd2, 24'h555555, 24'hAAAAAA);
		send(FUNC_LOAD, 6'd3, 24'hAAAAAA, 24'h555555);
		set_count(4);
		send(FUNC_QUERY, 6'd5, 24'h555555, 24'h555555);
		send(FUNC_QUERY, 6'd42, 24'hAAAAAA, 24'hAAAAAA);

		// Random phases, each under its own count
		for (int p = 0; p < PHASES; p++) begin
			set_count(phase_counts[p]);
			no_gaps = (p == CALM_PHASE);
			for (int i = 0; i < PHASE_LEN; i++)
				random_item();
		end
		no_gaps = 1'b0;

		drain();
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
